[sv/sgnr_pkg.sv]
// ----------------------------------------------------------------------------
// sgnr_pkg
// Shared types, constants and the glass map of the segment glass renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package sgnr_pkg;

    // Frame geometry
    localparam int NUM_ADDRS_DEF = 32;      // default nibbles per frame
    localparam int FRAME_NIBS    = 11;      // addresses 0..10 are held in a frame
    localparam int QUEUE_DEPTH   = 2;       // frames held between front and back
    localparam int OUT_ADDR_W    = 5;       // width of the nibble_address port

    // Value limits and digit split constants
    localparam logic [15:0] MAX_CLAMP   = 16'd9999;
    localparam logic [12:0] DIV10_MUL_W = 13'd6554;  // x / 10 = (x * 6554) >> 16
    localparam logic [7:0]  DIV10_MUL_N = 8'd205;    // x / 10 = (x * 205) >> 11

    // Icon positions
    localparam logic [3:0] COLON_ADDR = 4'd8;
    localparam logic [1:0] COLON_COM  = 2'd3;
    localparam logic [3:0] PM_ADDR    = 4'd3;
    localparam logic [1:0] PM_COM     = 2'd3;

    typedef logic [FRAME_NIBS-1:0][3:0] frame_t;
    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [1:0] com;
    } glass_pos_t;

    // Segment patterns, bit 0 = a ... bit 6 = g
    localparam logic [6:0] SEG_FONT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // [digit][segment a..g], digit 0 rightmost
    localparam glass_pos_t GLASS_MAP [4][7] = '{
        '{ '{1'b1, 4'd10, 2'd3}, '{1'b1, 4'd10, 2'd2}, '{1'b1, 4'd10, 2'd1},
           '{1'b1, 4'd9,  2'd1}, '{1'b1, 4'd8,  2'd1}, '{1'b1, 4'd9,  2'd3},
           '{1'b1, 4'd9,  2'd2} },
        '{ '{1'b1, 4'd8,  2'd2}, '{1'b1, 4'd7,  2'd3}, '{1'b1, 4'd7,  2'd1},
           '{1'b1, 4'd6,  2'd1}, '{1'b1, 4'd6,  2'd2}, '{1'b1, 4'd6,  2'd3},
           '{1'b1, 4'd7,  2'd2} },
        '{ '{1'b1, 4'd4,  2'd3}, '{1'b1, 4'd5,  2'd2}, '{1'b1, 4'd5,  2'd1},
           '{1'b1, 4'd4,  2'd1}, '{1'b1, 4'd3,  2'd1}, '{1'b1, 4'd3,  2'd2},
           '{1'b1, 4'd4,  2'd2} },
        '{ '{1'b0, 4'd0,  2'd0}, '{1'b1, 4'd2,  2'd2}, '{1'b1, 4'd2,  2'd1},
           '{1'b0, 4'd0,  2'd0}, '{1'b0, 4'd0,  2'd0}, '{1'b0, 4'd0,  2'd0},
           '{1'b1, 4'd1,  2'd2} }
    };

    // Map four digits and the icon flags onto the glass
    function automatic frame_t build_frame(
        input digit_t d3,
        input digit_t d2,
        input digit_t d1,
        input digit_t d0,
        input logic   colon,
        input logic   pm
    );
        frame_t     frame;
        digit_t     dig  [4];
        logic [3:0] show;
        logic [6:0] pat;
        glass_pos_t pos;
        frame   = '0;
        dig[0]  = d0;
        dig[1]  = d1;
        dig[2]  = d2;
        dig[3]  = d3;
        // leading zero blanking, rightmost digit always lit
        show[3] = (d3 != 4'd0);
        show[2] = show[3] || (d2 != 4'd0);
        show[1] = show[2] || (d1 != 4'd0);
        show[0] = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            pat = SEG_FONT[dig[i]];
            for (int s = 0; s < 7; s++)
            begin
                pos = GLASS_MAP[i][s];
                if (show[i] && pat[s] && pos.en)
                begin
                    frame[pos.addr][pos.com] = 1'b1;
                end
            end
        end
        if (colon)
        begin
            frame[COLON_ADDR][COLON_COM] = 1'b1;
        end
        if (pm)
        begin
            frame[PM_ADDR][PM_COM] = 1'b1;
        end
        return frame;
    endfunction

endpackage

`default_nettype wire

[sv/sgnr_front.sv]
// ----------------------------------------------------------------------------
// sgnr_front
// Input pipeline: saturates the value, splits it into decimal digits with one
// divide by ten per stage and renders the frame into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sgnr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [15:0]       value,
    input  wire logic              colon_lit,
    input  wire logic              pm_on,
    output logic                   push,
    output sgnr_pkg::frame_t       push_frame,
    input  wire logic              q_full
);

    // Stage 1: saturated value
    logic                  s1_v_reg;
    logic [13:0]           s1_x_reg;
    logic                  s1_colon_reg, s1_pm_reg;
    // Stage 2: value / 10 and units digit
    logic                  s2_v_reg;
    logic [9:0]            s2_q_reg;
    sgnr_pkg::digit_t      s2_d0_reg;
    logic                  s2_colon_reg, s2_pm_reg;
    // Stage 3: value / 100, tens and units
    logic                  s3_v_reg;
    logic [6:0]            s3_q_reg;
    sgnr_pkg::digit_t      s3_d1_reg, s3_d0_reg;
    logic                  s3_colon_reg, s3_pm_reg;
    // Stage 4: all four digits
    logic                  s4_v_reg;
    sgnr_pkg::digit_t      s4_d3_reg, s4_d2_reg, s4_d1_reg, s4_d0_reg;
    logic                  s4_colon_reg, s4_pm_reg;

    logic                  adv;
    logic [13:0]           s1_x_next;
    logic [26:0]           prod1;
    logic [9:0]            s2_q_next;
    logic [13:0]           rem1;
    logic [17:0]           prod2;
    logic [6:0]            s3_q_next;
    logic [9:0]            rem2;
    logic [14:0]           prod3;
    sgnr_pkg::digit_t      d3_next;
    logic [6:0]            rem3;

    // Whole pipeline moves unless a finished frame waits on a full queue
    assign adv      = !(s4_v_reg && q_full);
    assign in_stall = !adv;
    assign push     = s4_v_reg && !q_full;
    assign push_frame = sgnr_pkg::build_frame(s4_d3_reg, s4_d2_reg, s4_d1_reg,
                                              s4_d0_reg, s4_colon_reg, s4_pm_reg);

    // Saturate to four digits
    assign s1_x_next = (value > sgnr_pkg::MAX_CLAMP) ? sgnr_pkg::MAX_CLAMP[13:0]
                                                     : value[13:0];

    // Digit split, one reciprocal multiply per stage
    always_comb
    begin
        prod1     = 27'(s1_x_reg) * 27'(sgnr_pkg::DIV10_MUL_W);
        s2_q_next = prod1[25:16];
        rem1      = s1_x_reg - {1'b0, s2_q_next, 3'b000} - {3'b000, s2_q_next, 1'b0};

        prod2     = 18'(s2_q_reg) * 18'(sgnr_pkg::DIV10_MUL_N);
        s3_q_next = prod2[17:11];
        rem2      = s2_q_reg - {s3_q_next, 3'b000} - {2'b00, s3_q_next, 1'b0};

        prod3     = 15'(s3_q_reg) * 15'(sgnr_pkg::DIV10_MUL_N);
        d3_next   = prod3[14:11];
        rem3      = s3_q_reg - {d3_next[3:0], 3'b000} - {2'b00, d3_next, 1'b0};
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg     <= s1_x_next;
            s1_colon_reg <= colon_lit;
            s1_pm_reg    <= pm_on;

            s2_q_reg     <= s2_q_next;
            s2_d0_reg    <= rem1[3:0];
            s2_colon_reg <= s1_colon_reg;
            s2_pm_reg    <= s1_pm_reg;

            s3_q_reg     <= s3_q_next;
            s3_d1_reg    <= rem2[3:0];
            s3_d0_reg    <= s2_d0_reg;
            s3_colon_reg <= s2_colon_reg;
            s3_pm_reg    <= s2_pm_reg;

            s4_d3_reg    <= d3_next;
            s4_d2_reg    <= rem3[3:0];
            s4_d1_reg    <= s3_d1_reg;
            s4_d0_reg    <= s3_d0_reg;
            s4_colon_reg <= s3_colon_reg;
            s4_pm_reg    <= s3_pm_reg;
        end
    end

endmodule

`default_nettype wire

[sv/sgnr_queue.sv]
// ----------------------------------------------------------------------------
// sgnr_queue
// Small frame queue between the render pipeline and the nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sgnr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sgnr_pkg::frame_t  push_frame,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output sgnr_pkg::frame_t       head_frame
);

    localparam int PTR_W = $clog2(sgnr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sgnr_pkg::QUEUE_DEPTH + 1);

    sgnr_pkg::frame_t  mem_reg [sgnr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(sgnr_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_frame = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(sgnr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(sgnr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Frame storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

`default_nettype wire

[sv/sgnr_back.sv]
// ----------------------------------------------------------------------------
// sgnr_back
// Nibble sequencer: walks the head frame address by address into a
// registered output stage and releases the frame after its last nibble.
// ----------------------------------------------------------------------------
`default_nettype none

module sgnr_back #(
    parameter int NUM_ADDRS = sgnr_pkg::NUM_ADDRS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire sgnr_pkg::frame_t  head_frame,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [sgnr_pkg::OUT_ADDR_W-1:0] nibble_address,
    output logic [3:0]             nibble_data,
    output logic                   last
);

    localparam int ADDR_W = $clog2(NUM_ADDRS);
    localparam int IDX_W  = $clog2(sgnr_pkg::FRAME_NIBS);

    logic [ADDR_W-1:0]                   cnt_reg, cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic [sgnr_pkg::OUT_ADDR_W-1:0]     addr_reg;
    logic [3:0]                          data_reg;
    logic                                last_reg;

    logic                                load;
    logic                                at_last;
    logic [ADDR_W+sgnr_pkg::OUT_ADDR_W-1:0] cnt_ext;
    logic [3:0]                          data_next;

    assign cnt_ext = {{sgnr_pkg::OUT_ADDR_W{1'b0}}, cnt_reg};
    assign at_last = (cnt_reg == ADDR_W'(NUM_ADDRS - 1));
    assign load    = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = load && at_last;

    // Addresses past the glass carry no segments
    assign data_next = (cnt_reg < ADDR_W'(sgnr_pkg::FRAME_NIBS))
                     ? head_frame[cnt_ext[IDX_W-1:0]] : 4'd0;

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            cnt_next       = at_last ? '0 : cnt_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output item register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= cnt_ext[sgnr_pkg::OUT_ADDR_W-1:0];
            data_reg <= data_next;
            last_reg <= at_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign nibble_address = addr_reg;
    assign nibble_data    = data_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

[sv/segment_glass_number_render.sv]
// ----------------------------------------------------------------------------
// segment_glass_number_render
// Renders a saturated four-digit number plus colon and PM icons into the
// display-memory nibbles of a seven-segment glass.
// ----------------------------------------------------------------------------
// Each accepted item produces NUM_ADDRS output items (32 by default), one
// nibble per cycle while out_stall is low, in ascending address order with
// last on the final one; the nibble sequencer sets the sustained rate. A
// four-stage pipeline splits the value into digits and renders the frame,
// and a two-frame queue lets new items enter while the previous frame is
// still being sent.
`default_nettype none

module segment_glass_number_render #(
    parameter int NUM_ADDRS = sgnr_pkg::NUM_ADDRS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] value,
    input  wire logic        colon_lit,
    input  wire logic        pm_on,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       nibble_address,
    output logic [3:0]       nibble_data,
    output logic             last
);

    logic              push;
    sgnr_pkg::frame_t  push_frame;
    logic              q_full;
    logic              pop;
    logic              head_valid;
    sgnr_pkg::frame_t  head_frame;

    // Digit split and render
    sgnr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .colon_lit  (colon_lit),
        .pm_on      (pm_on),
        .push       (push),
        .push_frame (push_frame),
        .q_full     (q_full)
    );

    // Frame queue
    sgnr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    // Nibble sequencer
    sgnr_back #(
        .NUM_ADDRS (NUM_ADDRS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_frame     (head_frame),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .nibble_address (nibble_address),
        .nibble_data    (nibble_data),
        .last           (last)
    );

endmodule

`default_nettype wire

[tb/sgnr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgnr_checker
// Watches both channels of the glass renderer, predicts each frame and
// compares every nibble the block sends against the prediction.
// ----------------------------------------------------------------------------

module sgnr_checker #(
    parameter int NUM_ADDRS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [15:0] value,
    input  wire logic        colon_lit,
    input  wire logic        pm_on,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [4:0]  nibble_address,
    input  wire logic [3:0]  nibble_data,
    input  wire logic        last,
    output int               fail_count,
    output int               nibbles_waiting,
    output int               nibbles_checked,
    output int               frames_taken
);

    localparam int VALUE_CEILING = 9999;
    localparam int UNWIRED       = -1;

    // icon positions on the glass
    localparam int COLON_NIB = 8;
    localparam int COLON_BIT = 3;
    localparam int PM_NIB    = 3;
    localparam int PM_BIT    = 3;

    // segment patterns, bit 0 = a ... bit 6 = g
    localparam logic [6:0] DIGIT_SEGS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // nibble and common bit of each segment, digit 0 is the rightmost
    localparam int SEG_NIB [4][7] = '{
        '{10, 10, 10, 9, 8, 9, 9},
        '{ 8,  7,  7, 6, 6, 6, 7},
        '{ 4,  5,  5, 4, 3, 3, 4},
        '{UNWIRED, 2, 2, UNWIRED, UNWIRED, UNWIRED, 1}
    };
    localparam int SEG_BIT [4][7] = '{
        '{3, 2, 1, 1, 1, 3, 2},
        '{2, 3, 1, 1, 2, 3, 2},
        '{3, 2, 1, 1, 1, 2, 2},
        '{0, 2, 1, 0, 0, 0, 2}
    };

    typedef struct packed {
        logic [4:0] addr;
        logic [3:0] data;
        logic       last;
    } nibble_t;

    nibble_t pending_nibbles [$];

    // Light one common bit, ignoring addresses past the frame
    function automatic void light(ref logic [3:0] nibs [NUM_ADDRS], input int a,
                                  input int b);
        if (a >= 0 && a < NUM_ADDRS)
        begin
            nibs[a][b] = 1'b1;
        end
    endfunction

    // Render one frame and queue its nibbles in address order
    function automatic void queue_frame(input logic [15:0] num, input logic colon,
                                        input logic pm);
        int         rest;
        int         digit [4];
        logic       shown [4];
        logic [6:0] segs;
        logic [3:0] nibs [NUM_ADDRS];
        nibble_t    item;
        rest = (int'(num) > VALUE_CEILING) ? VALUE_CEILING : int'(num);
        for (int i = 0; i < 4; i++)
        begin
            digit[i] = rest % 10;
            rest     = rest / 10;
        end
        // blank leading zeros, the rightmost digit always shows
        shown[3] = (digit[3] != 0);
        shown[2] = shown[3] || (digit[2] != 0);
        shown[1] = shown[2] || (digit[1] != 0);
        shown[0] = 1'b1;
        for (int a = 0; a < NUM_ADDRS; a++)
        begin
            nibs[a] = 4'h0;
        end
        for (int i = 0; i < 4; i++)
        begin
            segs = DIGIT_SEGS[digit[i]];
            for (int s = 0; s < 7; s++)
            begin
                if (shown[i] && segs[s] && SEG_NIB[i][s] != UNWIRED)
                begin
                    light(nibs, SEG_NIB[i][s], SEG_BIT[i][s]);
                end
            end
        end
        if (colon)
        begin
            light(nibs, COLON_NIB, COLON_BIT);
        end
        if (pm)
        begin
            light(nibs, PM_NIB, PM_BIT);
        end
        for (int a = 0; a < NUM_ADDRS; a++)
        begin
            item.addr = 5'(a);
            item.data = nibs[a];
            item.last = (a == NUM_ADDRS - 1);
            pending_nibbles.push_back(item);
        end
    endfunction

    // Log one failure
    function automatic void flag(input string what, input int want, input int got);
        fail_count = fail_count + 1;
        $display("%0d ns: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    initial
    begin
        fail_count      = 0;
        nibbles_waiting = 0;
        nibbles_checked = 0;
        frames_taken    = 0;
    end

    // Sample both channels at the edge where the handshakes complete
    always @(posedge clk)
    begin
        nibble_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                queue_frame(value, colon_lit, pm_on);
                frames_taken = frames_taken + 1;
            end
            if (out_valid && !out_stall)
            begin
                nibbles_checked = nibbles_checked + 1;
                if (pending_nibbles.size() == 0)
                begin
                    flag("nibble with no frame waiting, address", 0,
                         int'(nibble_address));
                end
                else
                begin
                    want = pending_nibbles.pop_front();
                    if (nibble_address !== want.addr)
                    begin
                        flag("nibble_address", int'(want.addr), int'(nibble_address));
                    end
                    if (nibble_data !== want.data)
                    begin
                        flag($sformatf("nibble_data at address %0d", want.addr),
                             int'(want.data), int'(nibble_data));
                    end
                    if (last !== want.last)
                    begin
                        flag($sformatf("last at address %0d", want.addr),
                             int'(want.last), int'(last));
                    end
                end
            end
            nibbles_waiting = pending_nibbles.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives numbers and icon flags into the glass renderer under random idling
// on both sides; the checker beside the block predicts every frame.
// ----------------------------------------------------------------------------

module tb;

    localparam int NUM_ADDRS     = 32;
    localparam int RANDOM_ITEMS  = 140;
    localparam int QUIET_TAIL    = 30;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] value;
    logic        colon_lit;
    logic        pm_on;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  nibble_address;
    logic [3:0]  nibble_data;
    logic        last;

    int fail_count;
    int nibbles_waiting;
    int nibbles_checked;
    int frames_taken;
    int cycle_count;
    int saturated_count;
    int icon_count;
    bit idling_on;

    segment_glass_number_render #(
        .NUM_ADDRS(NUM_ADDRS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .colon_lit(colon_lit),
        .pm_on(pm_on),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .nibble_address(nibble_address),
        .nibble_data(nibble_data),
        .last(last)
    );

    sgnr_checker #(
        .NUM_ADDRS(NUM_ADDRS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .colon_lit(colon_lit),
        .pm_on(pm_on),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .nibble_address(nibble_address),
        .nibble_data(nibble_data),
        .last(last),
        .fail_count(fail_count),
        .nibbles_waiting(nibbles_waiting),
        .nibbles_checked(nibbles_checked),
        .frames_taken(frames_taken)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d nibbles still due",
                     cycle_count, nibbles_waiting);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall in random bursts while idling is on
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left = stall_left - 1;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 3) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one item and hold it until taken, sometimes after an idle burst
    task automatic send_item(input logic [15:0] num, input logic colon,
                             input logic pm);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        value     <= num;
        colon_lit <= colon;
        pm_on     <= pm;
        if (num > 16'd9999)
        begin
            saturated_count = saturated_count + 1;
        end
        if (colon || pm)
        begin
            icon_count = icon_count + 1;
        end
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Random value, weighted toward short numbers and the saturation edge
    function automatic logic [15:0] pick_value();
        logic [15:0] num;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: num = 16'($urandom_range(0, 9999));
            4, 5:       num = 16'($urandom_range(0, 99));
            6:          num = 16'($urandom_range(0, 999));
            7, 8:       num = 16'($urandom_range(10000, 65535));
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       num = 16'd0;
                    1:       num = 16'd9999;
                    2:       num = 16'd10000;
                    default: num = 16'hFFFF;
                endcase
            end
        endcase
        return num;
    endfunction

    // Stimulus and verdict
    initial
    begin
        saturated_count = 0;
        icon_count      = 0;
        idling_on       = 1'b1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        value     <= 16'd0;
        colon_lit <= 1'b0;
        pm_on     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero, single digits and leading-zero blanking
        send_item(16'd0, 1'b0, 1'b0);
        send_item(16'd7, 1'b0, 1'b0);
        send_item(16'd10, 1'b0, 1'b0);
        send_item(16'd100, 1'b0, 1'b0);
        send_item(16'd1000, 1'b0, 1'b0);
        send_item(16'd1007, 1'b0, 1'b0);
        send_item(16'd90, 1'b1, 1'b0);
        // every digit in some position, 8888 lights all segments
        send_item(16'd1234, 1'b0, 1'b0);
        send_item(16'd5678, 1'b0, 1'b1);
        send_item(16'd9012, 1'b1, 1'b0);
        send_item(16'd3456, 1'b0, 1'b0);
        send_item(16'd7890, 1'b1, 1'b1);
        send_item(16'd2468, 1'b0, 1'b0);
        send_item(16'd8888, 1'b1, 1'b1);
        // saturation edge and all-ones value
        send_item(16'd9999, 1'b0, 1'b0);
        send_item(16'd10000, 1'b0, 1'b0);
        send_item(16'hFFFF, 1'b1, 1'b1);
        send_item(16'h8000, 1'b0, 1'b1);
        // icons alone on a blank-heavy frame
        send_item(16'd0, 1'b1, 1'b0);
        send_item(16'd0, 1'b0, 1'b1);
        send_item(16'd0, 1'b1, 1'b1);

        // random part, idling switched off for the tail
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idling_on = (n < RANDOM_ITEMS - QUIET_TAIL);
            send_item(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;

        // let every queued frame drain
        while (nibbles_waiting != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d frames sent, %0d above the ceiling, %0d with an icon lit",
                 frames_taken, saturated_count, icon_count);
        $display("%0d nibbles compared, %0d failures", nibbles_checked, fail_count);
        if (fail_count == 0 && nibbles_waiting == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/sgnr_pkg.sv
sv/sgnr_front.sv
sv/sgnr_queue.sv
sv/sgnr_back.sv
sv/segment_glass_number_render.sv
tb/sgnr_checker.sv
tb/tb.sv
